### src/dsgb_pkg.sv
package dsgb_pkg;
  localparam int MaxVertices = 128;
  localparam int MaxEdges = 8192;
  localparam int VW = $clog2(MaxVertices);
  localparam int CW = $clog2(MaxVertices + 1);
  localparam int EW = $clog2(MaxEdges);
  localparam int ECW = $clog2(MaxEdges + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_IMPOSSIBLE = 2'd0,
    VERDICT_UNIQUE     = 2'd1,
    VERDICT_MULTIPLE   = 2'd2,
    VERDICT_NOT_RUN    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic run_start;
    logic read;
  } dsgb_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic full;
  } dsgb_stat_t;
endpackage

### src/dsgb_datapath.sv
module dsgb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  dsgb_pkg::dsgb_cmd_t cmd,
  input  logic [7:0]          degree,
  input  logic [12:0]         edge_index,
  input  logic                alternative,
  output dsgb_pkg::dsgb_stat_t stat,
  output logic [1:0]          verdict,
  output logic [12:0]         edges_total,
  output logic [7:0]          edge_from,
  output logic [7:0]          edge_to,
  output logic                overflow
);
  import dsgb_pkg::*;

  // run sequencer phases
  typedef enum logic [7:0] {
    P_IDLE  = 8'b00000001,
    P_SORTK = 8'b00000010,
    P_SORTL = 8'b00000100,
    P_SORTP = 8'b00001000,
    P_TOP   = 8'b00010000,
    P_CONN  = 8'b00100000,
    P_CHECK = 8'b01000000,
    P_DONE  = 8'b10000000
  } ph_t;

  ph_t ph_r;
  logic [7:0] deg_mem [MaxVertices];
  logic [7:0] id_mem [MaxVertices];
  logic [7:0] from_mem [MaxEdges];
  logic [7:0] to_mem [MaxEdges];

  logic [CW-1:0]  vcount_r, i_r, k_r, p_r, j_r, jend_r;
  logic           odd_r, mult_r;
  logic [ECW-1:0] ecount_r;
  logic [1:0]     verdict_r;
  logic [EW-1:0]  spos_r;
  logic [7:0]     star_r, spar_r;
  logic [7:0]     kd_r, kid_r, topid_r, prevd_r, previd_r;
  logic [7:0]     rdf_r, rdt_r;
  logic [12:0]    ridx_r;
  logic           ralt_r;

  // one registered read of the vertex stores per cycle; the address is the entry
  // that the next phase works on
  logic [VW-1:0] ra;
  logic [7:0]    rdd_r, rdi_r;

  always_comb begin
    unique case (ph_r)
      P_SORTK: ra = (k_r >= vcount_r) ? i_r[VW-1:0] : k_r[VW-1:0];
      P_SORTL: ra = VW'(k_r - 1'b1);
      P_SORTP: ra = VW'(p_r - 2'd2);
      P_TOP:   ra = VW'(i_r + 1'b1);
      P_CONN:  ra = VW'(j_r + 1'b1);
      default: ra = '0;
    endcase
  end

  function automatic logic [7:0] relab(input logic [7:0] x, input logic [7:0] t,
                                       input logic [7:0] q);
    if (x == t) return q;
    else if (x == q) return t;
    else return x;
  endfunction

  always_ff @(posedge clk) begin
    rdd_r <= deg_mem[ra];
    rdi_r <= id_mem[ra];
    if (cmd.read) begin
      rdf_r <= from_mem[edge_index[EW-1:0]];
      rdt_r <= to_mem[edge_index[EW-1:0]];
      ridx_r <= edge_index;
      ralt_r <= alternative;
    end
    if (cmd.load && vcount_r < CW'(MaxVertices)) begin
      deg_mem[vcount_r[VW-1:0]] <= degree;
      id_mem[vcount_r[VW-1:0]] <= 8'(vcount_r + 1'b1);
    end
    unique case (ph_r)
      P_SORTP: if (p_r > i_r && rdd_r < kd_r) begin
        deg_mem[p_r[VW-1:0]] <= rdd_r;
        id_mem[p_r[VW-1:0]] <= rdi_r;
      end else begin
        deg_mem[p_r[VW-1:0]] <= kd_r;
        id_mem[p_r[VW-1:0]] <= kid_r;
      end
      P_CONN: if (rdd_r != 8'd0 && ecount_r < ECW'(MaxEdges)) begin
        deg_mem[j_r[VW-1:0]] <= rdd_r - 8'd1;
        from_mem[ecount_r[EW-1:0]] <= topid_r;
        to_mem[ecount_r[EW-1:0]] <= rdi_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      vcount_r <= '0; odd_r <= 1'b0; ecount_r <= '0;
      verdict_r <= VERDICT_NOT_RUN;
      spos_r <= '0; star_r <= '0; spar_r <= '0;
      i_r <= '0; k_r <= '0; p_r <= '0; j_r <= '0; jend_r <= '0; mult_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        vcount_r <= '0; odd_r <= 1'b0; ecount_r <= '0;
        verdict_r <= VERDICT_NOT_RUN;
        spos_r <= '0; star_r <= '0; spar_r <= '0;
      end
      if (cmd.load && vcount_r < CW'(MaxVertices)) begin
        vcount_r <= vcount_r + 1'b1;
        odd_r <= odd_r ^ degree[0];
        verdict_r <= VERDICT_NOT_RUN;
        ecount_r <= '0;
      end
      unique case (ph_r)
        P_IDLE: if (cmd.run_start) begin
          ecount_r <= '0; spos_r <= '0; star_r <= '0; spar_r <= '0;
          mult_r <= 1'b0;
          i_r <= '0;
          k_r <= CW'(1);
          if (odd_r) begin
            verdict_r <= VERDICT_IMPOSSIBLE;
            ph_r <= P_DONE;
          end else if (vcount_r == '0) begin
            verdict_r <= VERDICT_UNIQUE;
            ph_r <= P_DONE;
          end else ph_r <= P_SORTK;
        end
        P_SORTK: if (k_r >= vcount_r) ph_r <= P_TOP;
          else ph_r <= P_SORTL;
        P_SORTL: begin
          kd_r <= rdd_r; kid_r <= rdi_r; p_r <= k_r; ph_r <= P_SORTP;
        end
        P_SORTP: if (p_r > i_r && rdd_r < kd_r) p_r <= p_r - 1'b1;
          else begin
            k_r <= k_r + 1'b1; ph_r <= P_SORTK;
          end
        P_TOP: begin
          if ((CW+1)'(i_r) + (CW+1)'(rdd_r) >= (CW+1)'(vcount_r)) begin
            verdict_r <= VERDICT_IMPOSSIBLE; ecount_r <= '0; ph_r <= P_DONE;
          end else if (rdd_r == 8'd0) begin
            verdict_r <= mult_r ? VERDICT_MULTIPLE : VERDICT_UNIQUE; ph_r <= P_DONE;
          end else begin
            topid_r <= rdi_r;
            j_r <= i_r + 1'b1;
            jend_r <= i_r + CW'(rdd_r);
            ph_r <= P_CONN;
          end
        end
        P_CONN: begin
          if (rdd_r == 8'd0 || ecount_r >= ECW'(MaxEdges)) begin
            verdict_r <= VERDICT_IMPOSSIBLE; ecount_r <= '0; ph_r <= P_DONE;
          end else begin
            ecount_r <= ecount_r + 1'b1;
            prevd_r <= rdd_r - 8'd1; previd_r <= rdi_r;
            j_r <= j_r + 1'b1;
            if (j_r == jend_r) ph_r <= P_CHECK;
          end
        end
        P_CHECK: begin
          if (j_r < vcount_r && {1'b0, rdd_r} == {1'b0, prevd_r} + 9'd1) begin
            mult_r <= 1'b1;
            spos_r <= EW'(ecount_r - 1'b1);
            star_r <= rdi_r; spar_r <= previd_r;
          end
          if (i_r + 1'b1 >= vcount_r) begin
            verdict_r <= (mult_r ||
                          (j_r < vcount_r && {1'b0, rdd_r} == {1'b0, prevd_r} + 9'd1))
                         ? VERDICT_MULTIPLE : VERDICT_UNIQUE;
            ph_r <= P_DONE;
          end else begin
            i_r <= i_r + 1'b1; k_r <= i_r + 2'd2; ph_r <= P_SORTK;
          end
        end
        P_DONE: ph_r <= P_IDLE;
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  assign stat.busy = (ph_r != P_IDLE);
  assign stat.done = (ph_r == P_DONE);
  assign stat.full = (vcount_r == CW'(MaxVertices));

  // read result, registered on the read command and formed in the cycle after it
  logic rd_bad;
  assign rd_bad = (verdict_r != VERDICT_UNIQUE && verdict_r != VERDICT_MULTIPLE) ||
                  ({3'b0, ridx_r} >= 16'(ecount_r)) || (32'(ridx_r) >= MaxEdges);
  always_comb begin
    edge_from = 8'd0; edge_to = 8'd0; overflow = 1'b0;
    if (rd_bad) overflow = 1'b1;
    else begin
      edge_from = rdf_r; edge_to = rdt_r;
      if (ralt_r && verdict_r == VERDICT_MULTIPLE) begin
        if (32'(ridx_r) == 32'(spos_r)) edge_to = star_r;
        else if (32'(ridx_r) > 32'(spos_r)) begin
          edge_from = relab(rdf_r, star_r, spar_r);
          edge_to = relab(rdt_r, star_r, spar_r);
        end
      end
    end
  end
  assign verdict = verdict_r;
  assign edges_total = 13'(ecount_r);

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) vcount_r <= CW'(MaxVertices))
    else $error("vertex count past capacity");
  a_edges: assert property (@(posedge clk) disable iff (!rst_n) ecount_r <= ECW'(MaxEdges))
    else $error("edge count past capacity");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == P_DONE) |=> (ph_r == P_IDLE)) else $error("done not followed by idle");
endmodule

### src/dsgb_ctrl.sv
module dsgb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dsgb_pkg::dsgb_cmd_t  cmd,
  input  dsgb_pkg::dsgb_stat_t stat,
  output logic                 sel_read
);
  import dsgb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } st_t;

  st_t st_r, st_nxt;
  logic take;
  logic rd_r, rd_nxt;

  assign in_ready = (st_r == S_IDLE);
  assign take = in_valid && in_ready;
  assign out_valid = (st_r == S_OUT);
  assign sel_read = rd_r;

  always_comb begin
    cmd.clear = take && in_command == CMD_CLEAR;
    cmd.load = take && in_command == CMD_LOAD;
    cmd.run_start = take && in_command == CMD_RUN;
    cmd.read = take && in_command == CMD_READ;
    st_nxt = st_r;
    rd_nxt = rd_r;
    unique case (st_r)
      S_IDLE: if (take) begin
        rd_nxt = cmd.read;
        st_nxt = cmd.run_start ? S_RUN : S_OUT;
      end
      S_RUN: if (stat.done) st_nxt = S_OUT;
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; rd_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rd_r <= rd_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during result");
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RUN && !stat.done) |=> (st_r == S_RUN || st_r == S_OUT))
    else $error("run left early");
endmodule

### src/degree_sequence_graph_builder.sv
// Load, clear and read words: result valid the cycle after the word is taken; the next
//   word is taken the cycle after the result leaves.
// Run word: per step i, a stable insertion sort orders the tail by degree, then the top
//   is fetched, its d neighbors are connected and the next neighbor is checked.
// Reset (rst_n low, synchronous): verdict not run, counts and swap registers zero;
//   stores hold garbage until written and need no clearing pass.
module degree_sequence_graph_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_degree,
  input  logic [12:0] in_edge_index,
  input  logic        in_alternative,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict,
  output logic [12:0] out_edges_total,
  output logic [7:0]  out_edge_from,
  output logic [7:0]  out_edge_to,
  output logic        out_overflow
);
  import dsgb_pkg::*;

  dsgb_cmd_t  cmd;
  dsgb_stat_t stat;
  logic       sel_read;
  logic [7:0] efrom, eto;
  logic       ovf_rd;
  logic       load_ovf_r;

  // controller: handshake and sequencing
  dsgb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_command,
    .out_valid, .out_ready, .cmd, .stat, .sel_read
  );

  // datapath: stores, sorter, edge writer, read relabel
  dsgb_datapath u_dp (
    .clk, .rst_n, .cmd, .degree(in_degree), .edge_index(in_edge_index),
    .alternative(in_alternative), .stat, .verdict(out_verdict),
    .edges_total(out_edges_total), .edge_from(efrom), .edge_to(eto),
    .overflow(ovf_rd)
  );

  // hold the load-full flag for the result word
  always_ff @(posedge clk) begin
    if (!rst_n) load_ovf_r <= 1'b0;
    else if (in_valid && in_ready) load_ovf_r <= cmd.load && stat.full;
  end

  assign out_edge_from = sel_read ? efrom : 8'd0;
  assign out_edge_to = sel_read ? eto : 8'd0;
  assign out_overflow = sel_read ? ovf_rd : load_ovf_r;
endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsgb_pkg::*;

  // Cycles with no word moving on either channel before the run is given up.
  // The slowest run word here is one of 30 vertices.
  localparam int WatchdogLimit = 100000;
  localparam int MaxRandSize = 30;

  typedef struct packed {
    verdict_t    verdict;
    logic [12:0] total;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic        ovf;
  } result_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  degree;
    logic [12:0] index;
    logic        alt;
    logic        fixed;
    result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_CLEAR;
  logic [7:0]  in_degree = '0;
  logic [12:0] in_edge_index = '0;
  logic        in_alternative = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_verdict;
  logic [12:0] out_edges_total;
  logic [7:0]  out_edge_from;
  logic [7:0]  out_edge_to;
  logic        out_overflow;

  degree_sequence_graph_builder dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the builder's state.
  logic [7:0]  degree_seq [MaxVertices];
  logic [7:0]  vertex_ids [MaxVertices];
  logic [7:0]  edge_src [MaxEdges];
  logic [7:0]  edge_dst [MaxEdges];
  int          n_vert = 0;
  logic        odd_flag = 1'b0;
  int          n_edges = 0;
  verdict_t    verdict_now = VERDICT_NOT_RUN;
  int          alt_pos = 0;
  logic [7:0]  alt_target = '0;
  logic [7:0]  alt_partner = '0;

  result_t     pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          words_sent = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  // Sample both handshakes at the falling edge ahead of the edge that moves them;
  // inputs only change at rising edges, so these values are what that edge sees.
  always @(negedge clk) begin
    in_fire  <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
  end

  // Stable insertion sort of the tail, descending by degree.
  task automatic sort_tail(input int lo);
    int         p;
    logic [7:0] d, id;
    for (int k = lo + 1; k < n_vert; k++) begin
      d = degree_seq[k];
      id = vertex_ids[k];
      p = k;
      while (p > lo && degree_seq[p-1] < d) begin
        degree_seq[p] = degree_seq[p-1];
        vertex_ids[p] = vertex_ids[p-1];
        p--;
      end
      degree_seq[p] = d;
      vertex_ids[p] = id;
    end
  endtask

  task automatic realize_seq(output verdict_t v);
    int   d, j;
    logic multi;
    multi = 1'b0;
    v = VERDICT_UNIQUE;
    for (int i = 0; i < n_vert; i++) begin
      sort_tail(i);
      d = degree_seq[i];
      if (i + d >= n_vert) begin
        v = VERDICT_IMPOSSIBLE;
        return;
      end
      if (d == 0) break;
      for (j = i + 1; j <= i + d; j++) begin
        if (degree_seq[j] == 0) begin
          v = VERDICT_IMPOSSIBLE;
          return;
        end
        degree_seq[j]--;
        if (n_edges >= MaxEdges) begin
          v = VERDICT_IMPOSSIBLE;
          return;
        end
        edge_src[n_edges] = vertex_ids[i];
        edge_dst[n_edges] = vertex_ids[j];
        n_edges++;
      end
      // A neighbor just past the run, one degree higher, gives a second realization.
      if (j < n_vert && int'(degree_seq[j]) == int'(degree_seq[j-1]) + 1) begin
        multi = 1'b1;
        alt_pos = n_edges - 1;
        alt_target = vertex_ids[j];
        alt_partner = vertex_ids[j-1];
      end
    end
    v = multi ? VERDICT_MULTIPLE : VERDICT_UNIQUE;
  endtask

  function automatic logic [7:0] swap_label(input logic [7:0] x);
    if (x == alt_target) return alt_partner;
    if (x == alt_partner) return alt_target;
    return x;
  endfunction

  // Advance the shadow state by one accepted word and return what must come out.
  task automatic predict_word(input cmd_t cmd, input logic [7:0] deg,
                              input logic [12:0] idx, input logic alt,
                              output result_t r);
    verdict_t v;
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        n_vert = 0;
        odd_flag = 1'b0;
        n_edges = 0;
        verdict_now = VERDICT_NOT_RUN;
        alt_pos = 0;
        alt_target = '0;
        alt_partner = '0;
      end
      CMD_LOAD: begin
        if (n_vert >= MaxVertices) begin
          r.ovf = 1'b1;
        end else begin
          degree_seq[n_vert] = deg;
          vertex_ids[n_vert] = 8'(n_vert + 1);
          n_vert++;
          odd_flag ^= deg[0];
          verdict_now = VERDICT_NOT_RUN;
          n_edges = 0;
        end
      end
      CMD_RUN: begin
        n_edges = 0;
        alt_pos = 0;
        alt_target = '0;
        alt_partner = '0;
        if (odd_flag) v = VERDICT_IMPOSSIBLE;
        else realize_seq(v);
        verdict_now = v;
        if (v == VERDICT_IMPOSSIBLE) n_edges = 0;
      end
      default: begin
        if ((verdict_now != VERDICT_UNIQUE && verdict_now != VERDICT_MULTIPLE) ||
            idx >= n_edges) begin
          r.ovf = 1'b1;
        end else begin
          r.src = edge_src[idx];
          r.dst = edge_dst[idx];
          if (alt && verdict_now == VERDICT_MULTIPLE) begin
            if (idx == alt_pos) begin
              r.dst = alt_target;
            end else if (idx > alt_pos) begin
              r.src = swap_label(r.src);
              r.dst = swap_label(r.dst);
            end
          end
        end
      end
    endcase
    r.verdict = verdict_now;
    r.total = 13'(n_edges);
  endtask

  // Present one word, hold it until taken, and queue its expected result.
  // Valid is left high afterwards; the next call lowers it only for an idle gap.
  task automatic send_word(input cmd_t cmd, input logic [7:0] deg, input logic [12:0] idx,
                           input logic alt, input logic fixed, input result_t want);
    result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_degree <= deg;
    in_edge_index <= idx;
    in_alternative <= alt;
    do @(posedge clk); while (!in_fire);
    words_sent++;
    predict_word(cmd, deg, idx, alt, r);
    if (fixed && r != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row disagrees with predictor: cmd %0d typed %h predicted %h",
                 cmd, want, r);
    end
    pending_results.push_back(fixed ? want : r);
  endtask

  task automatic send(input cmd_t cmd, input logic [7:0] deg = '0,
                      input logic [12:0] idx = '0, input logic alt = 1'b0);
    send_word(cmd, deg, idx, alt, 1'b0, '0);
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_fire) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: verdict %0d", out_verdict);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_verdict !== exp_r.verdict || out_edges_total !== exp_r.total ||
            out_edge_from !== exp_r.src || out_edge_to !== exp_r.dst ||
            out_overflow !== exp_r.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected v%0d n%0d %0d-%0d o%0d, got v%0d n%0d %0d-%0d o%0d",
                     exp_r.verdict, exp_r.total, exp_r.src, exp_r.dst, exp_r.ovf,
                     out_verdict, out_edges_total, out_edge_from, out_edge_to,
                     out_overflow);
        end
      end
    end
  end

  // Watchdog: give up when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed words; typed results only where they are plain to see.
  localparam int NumRows = 25;
  localparam result_t Fresh = '{VERDICT_NOT_RUN, 13'd0, 8'd0, 8'd0, 1'b0};
  localparam result_t FreshBad = '{VERDICT_NOT_RUN, 13'd0, 8'd0, 8'd0, 1'b1};
  localparam result_t Dead = '{VERDICT_IMPOSSIBLE, 13'd0, 8'd0, 8'd0, 1'b0};
  localparam result_t DeadBad = '{VERDICT_IMPOSSIBLE, 13'd0, 8'd0, 8'd0, 1'b1};
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{CMD_READ,  8'd0,   13'h1fff, 1'b1, 1'b1, FreshBad}, // read before any run
    '{CMD_RUN,   8'd0,   13'd0,    1'b0, 1'b0, '0},       // empty sequence
    '{CMD_CLEAR, 8'd0,   13'd0,    1'b0, 1'b1, Fresh},
    '{CMD_LOAD,  8'd255, 13'd0,    1'b0, 1'b1, Fresh},
    '{CMD_RUN,   8'd0,   13'd0,    1'b0, 1'b1, Dead},     // odd count of odd degrees
    '{CMD_READ,  8'd0,   13'd0,    1'b0, 1'b1, DeadBad},
    '{CMD_LOAD,  8'd1,   13'd0,    1'b0, 1'b1, Fresh},
    '{CMD_RUN,   8'd0,   13'd0,    1'b0, 1'b1, Dead},     // degree too large
    '{CMD_CLEAR, 8'd0,   13'd0,    1'b0, 1'b1, Fresh},
    '{CMD_LOAD,  8'd2,   13'd0,    1'b0, 1'b0, '0},       // 2,2,0,0: degree goes negative
    '{CMD_LOAD,  8'd2,   13'd0,    1'b0, 1'b0, '0},
    '{CMD_LOAD,  8'd0,   13'd0,    1'b0, 1'b0, '0},
    '{CMD_LOAD,  8'd0,   13'd0,    1'b0, 1'b0, '0},
    '{CMD_RUN,   8'd0,   13'd0,    1'b0, 1'b1, Dead},
    '{CMD_CLEAR, 8'd0,   13'd0,    1'b0, 1'b1, Fresh},
    '{CMD_LOAD,  8'd1,   13'd0,    1'b0, 1'b0, '0},       // 1,1,1,1: two realizations
    '{CMD_LOAD,  8'd1,   13'd0,    1'b0, 1'b0, '0},
    '{CMD_LOAD,  8'd1,   13'd0,    1'b0, 1'b0, '0},
    '{CMD_LOAD,  8'd1,   13'd0,    1'b0, 1'b0, '0},
    '{CMD_RUN,   8'd0,   13'd0,    1'b0, 1'b0, '0},
    '{CMD_READ,  8'd0,   13'd1,    1'b1, 1'b0, '0},
    '{CMD_READ,  8'd0,   13'd1,    1'b0, 1'b0, '0},
    '{CMD_READ,  8'd0,   13'd2,    1'b1, 1'b0, '0},       // past the last edge
    '{CMD_RUN,   8'd0,   13'd0,    1'b0, 1'b0, '0},       // rerun on residual degrees
    '{CMD_LOAD,  8'd0,   13'd0,    1'b0, 1'b0, '0}        // load after a run
  };

  task automatic random_sequence();
    int         n, prob, kind, reads, top;
    logic [7:0] deg [MaxRandSize];
    n = ($urandom_range(9) == 0) ? $urandom_range(MaxRandSize) : $urandom_range(1, 10);
    kind = $urandom_range(99);
    prob = $urandom_range(10, 90);
    for (int i = 0; i < n; i++) deg[i] = '0;
    // Mostly degrees of a real random graph, so the run goes deep; the rest is noise.
    for (int i = 0; i < n; i++) begin
      if (kind < 75) begin
        for (int j = i + 1; j < n; j++)
          if ($urandom_range(99) < prob) begin
            deg[i]++;
            deg[j]++;
          end
      end else if (kind < 92) begin
        deg[i] = 8'($urandom_range(n));
      end else begin
        deg[i] = 8'($urandom_range(255));
      end
    end
    if ($urandom_range(9) != 0) send(CMD_CLEAR);
    for (int i = 0; i < n; i++) send(CMD_LOAD, deg[i]);
    send(CMD_RUN);
    if ($urandom_range(7) == 0) send(CMD_RUN);
    reads = $urandom_range(2, 8);
    for (int k = 0; k < reads; k++) begin
      top = (n_edges > 0) ? n_edges : 1;
      if ($urandom_range(7) == 0)
        send(CMD_READ, 8'($urandom), 13'($urandom), 1'($urandom));
      else
        send(CMD_READ, 8'($urandom), 13'($urandom_range(top)), 1'($urandom));
    end
    if ($urandom_range(11) == 0) begin
      send(CMD_LOAD, 8'($urandom_range(3)));
      send(CMD_READ, '0, '0, 1'b1);
    end
  endtask

  initial begin
    int seg;
    seg = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[r])
      send_word(DirectedRows[r].cmd, DirectedRows[r].degree, DirectedRows[r].index,
                DirectedRows[r].alt, DirectedRows[r].fixed, DirectedRows[r].want);

    // Fill the vertex store to capacity, then one more load overflows.
    send(CMD_CLEAR);
    for (int i = 0; i <= MaxVertices; i++) send(CMD_LOAD, 8'd0);
    send(CMD_RUN);
    send(CMD_READ, '0, '0, 1'b0);

    // Random part, rotating through the idling phases.
    while (words_sent < 1300) begin
      case (seg % 5)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        3: begin send_idle_pct = 35; recv_stall_pct = 35; end
        default: begin
          send_idle_pct = $urandom_range(50);
          recv_stall_pct = $urandom_range(50);
        end
      endcase
      // Once, hold the receiver off while words keep coming so the input backs up.
      if (seg == 7) begin
        send_idle_pct = 0;
        hold_request = 400;
      end
      random_sequence();
      seg++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
